[hdl/wta_pkg.sv]
// Shared constants, types and command/status bundles for the trapezoid averaging core.
package wta_pkg;

  localparam int unsigned ChannelsDefault = 1024;
  localparam int unsigned IndexW = 10;
  localparam int unsigned SampleW = 32;
  localparam int unsigned TimeW = 32;
  localparam int unsigned StepW = 16;
  localparam int unsigned SumW = 64;
  localparam int unsigned DivSteps = 64;
  localparam logic [TimeW-1:0] WindowReset = 32'd1000;

  typedef enum logic [1:0] {
    MODE_CONTINUE   = 2'd0,
    MODE_BACKWARDS  = 2'd1,
    MODE_NEW_WINDOW = 2'd2
  } mode_e;

  typedef struct packed {
    logic clear_en;
    logic accept;
    logic mul;
    logic acc;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic need_div;
    logic div_last;
  } sts_t;

endpackage

[hdl/windowed_trapezoid_average_core.sv]
// Top level of the windowed trapezoidal time-weighted averaging core.
// Each request passes through accept, memory read and multiply, accumulate and
// write back, and output load when the result is the sample itself; when an
// average is computed, a radix-2 divider that retires one quotient bit per cycle
// over 64 steps runs between accumulate and output load. After reset the channel
// memories are swept to zero, one entry per cycle, before the first request is
// accepted; window length writes are taken at any time.
module windowed_trapezoid_average_core #(
  parameter int unsigned Channels = wta_pkg::ChannelsDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               window_length_we_i,
  input  logic [wta_pkg::TimeW-1:0]          window_length_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [wta_pkg::SampleW-1:0] force_sample_i,
  input  logic [wta_pkg::IndexW-1:0]         channel_index_i,
  input  logic                               first_of_call_i,
  input  logic [wta_pkg::TimeW-1:0]          current_time_i,
  input  logic [wta_pkg::StepW-1:0]          step_length_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [wta_pkg::SampleW-1:0] average_force_o,
  output logic [wta_pkg::IndexW-1:0]         channel_echo_o
);

  wta_pkg::cmd_t cmd;
  wta_pkg::sts_t sts;

  wta_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  wta_datapath #(
    .Channels (Channels)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .window_length_we_i (window_length_we_i),
    .window_length_i    (window_length_i),
    .force_sample_i     (force_sample_i),
    .channel_index_i    (channel_index_i),
    .first_of_call_i    (first_of_call_i),
    .current_time_i     (current_time_i),
    .step_length_i      (step_length_i),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .average_force_o    (average_force_o),
    .channel_echo_o     (channel_echo_o)
  );

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted while another is in flight");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.load_out))
    else $error("result valid without an output load");

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clear_en |-> !in_ready_o)
    else $error("request accepted during memory clear");

endmodule

[hdl/wta_ctrl.sv]
// Controller state machine sequencing clear, load, accumulate, divide and output.
module wta_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  wta_pkg::sts_t sts_i,
  output wta_pkg::cmd_t cmd_o
);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_LOAD  = 6'b000100,
    ST_ACC   = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_en = 1'b1;
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o.mul = 1'b1;
        state_d = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        state_d = sts_i.need_div ? ST_DIV : ST_DONE;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[hdl/wta_datapath.sv]
// Datapath: channel memories, call mode, trapezoid accumulate and serial divider.
module wta_datapath #(
  parameter int unsigned Channels = wta_pkg::ChannelsDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                window_length_we_i,
  input  logic [wta_pkg::TimeW-1:0]           window_length_i,
  input  logic signed [wta_pkg::SampleW-1:0]  force_sample_i,
  input  logic [wta_pkg::IndexW-1:0]          channel_index_i,
  input  logic                                first_of_call_i,
  input  logic [wta_pkg::TimeW-1:0]           current_time_i,
  input  logic [wta_pkg::StepW-1:0]           step_length_i,
  input  wta_pkg::cmd_t                       cmd_i,
  output wta_pkg::sts_t                       sts_o,
  output logic signed [wta_pkg::SampleW-1:0]  average_force_o,
  output logic [wta_pkg::IndexW-1:0]          channel_echo_o
);

  localparam int unsigned AddrW = (Channels > 1) ? $clog2(Channels) : 1;
  localparam int unsigned SW = wta_pkg::SumW;
  localparam int unsigned XW = wta_pkg::SampleW;
  localparam int unsigned TW = wta_pkg::TimeW;
  localparam int unsigned CntW = $clog2(wta_pkg::DivSteps);

  logic [SW-1:0] sum_mem [Channels];
  logic [XW-1:0] prev_mem [Channels];
  logic [XW-1:0] ws_mem [Channels];

  logic [TW-1:0]  wl_q, elapsed_q, last_q;
  wta_pkg::mode_e mode_q, mode_d;
  logic [TW-1:0]  elapsed_d, el_base;
  logic [TW:0]    el_sum;

  logic signed [XW-1:0] cur_q;
  logic [wta_pkg::IndexW-1:0] ch_q;
  logic [wta_pkg::StepW-1:0] dt_q;
  logic [AddrW-1:0] addr_in, addr_q, clr_cnt_q;
  logic in_range_q;

  logic [SW-1:0] sum_rd_q;
  logic [XW-1:0] prev_rd_q, ws_rd_q;
  logic [SW-1:0] sum_eff_q;
  logic [XW-1:0] ws_new_q;
  logic signed [XW:0] pair;
  logic signed [XW-1:0] prev_eff;
  logic signed [XW+wta_pkg::StepW:0] prod_q;

  logic [SW:0]   sum_ext;
  logic [SW-1:0] sum_new, mag;
  logic          neg_q;
  logic [SW-1:0] n_q;
  logic [XW+1:0] rem_q, rem_sh, rem_sub;
  logic [XW:0]   dvs;
  logic [CntW-1:0] div_cnt_q;
  logic [XW-1:0] avg_res;

  assign addr_in = AddrW'(channel_index_i);

  // Call mode and elapsed window time for the first request of a call
  always_comb begin
    mode_d = mode_q;
    if (current_time_i < last_q) begin
      mode_d = wta_pkg::MODE_BACKWARDS;
    end else if (elapsed_q >= wl_q) begin
      mode_d = wta_pkg::MODE_NEW_WINDOW;
    end else begin
      mode_d = wta_pkg::MODE_CONTINUE;
    end
    el_base = (mode_d == wta_pkg::MODE_CONTINUE) ? elapsed_q : '0;
    el_sum = {1'b0, el_base} + (TW+1)'(step_length_i);
    elapsed_d = el_sum[TW] ? '1 : el_sum[TW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q <= wta_pkg::WindowReset;
      elapsed_q <= '0;
      last_q <= '0;
      mode_q <= wta_pkg::MODE_CONTINUE;
      clr_cnt_q <= '0;
      div_cnt_q <= '0;
    end else begin
      if (window_length_we_i) begin
        wl_q <= window_length_i;
      end
      if (cmd_i.accept && first_of_call_i) begin
        mode_q <= mode_d;
        elapsed_q <= elapsed_d;
        last_q <= current_time_i;
      end
      if (cmd_i.clear_en) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (cmd_i.acc) begin
        div_cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q + 1'b1;
      end
    end
  end

  assign sts_o.clear_last = (clr_cnt_q == AddrW'(Channels - 1));
  assign sts_o.need_div = in_range_q && (elapsed_q != '0);
  assign sts_o.div_last = (div_cnt_q == CntW'(wta_pkg::DivSteps - 1));

  // Channel memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_en) begin
      sum_mem[clr_cnt_q] <= '0;
      prev_mem[clr_cnt_q] <= '0;
      ws_mem[clr_cnt_q] <= '0;
    end else if (cmd_i.acc && in_range_q) begin
      sum_mem[addr_q] <= sum_new;
      prev_mem[addr_q] <= cur_q;
      ws_mem[addr_q] <= ws_new_q;
    end
    if (cmd_i.accept) begin
      sum_rd_q <= sum_mem[addr_in];
      prev_rd_q <= prev_mem[addr_in];
      ws_rd_q <= ws_mem[addr_in];
    end
  end

  always_comb begin
    prev_eff = (mode_q == wta_pkg::MODE_BACKWARDS) ? ws_rd_q : prev_rd_q;
    pair = {prev_eff[XW-1], prev_eff} + {cur_q[XW-1], cur_q};
    sum_ext = {sum_eff_q[SW-1], sum_eff_q} + SW'(prod_q) + {prod_q[XW+wta_pkg::StepW],
              {SW{1'b0}}};
    if (sum_ext[SW] != sum_ext[SW-1]) begin
      sum_new = sum_ext[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end else begin
      sum_new = sum_ext[SW-1:0];
    end
    mag = sum_new[SW-1] ? (~sum_new + 1'b1) : sum_new;
    dvs = {elapsed_q, 1'b0};
    rem_sh = {rem_q[XW:0], n_q[SW-1]};
    rem_sub = rem_sh - {1'b0, dvs};
    if (neg_q) begin
      avg_res = (n_q > SW'(64'h8000_0000)) ? 32'h8000_0000 : XW'(~n_q + 1'b1);
    end else begin
      avg_res = (n_q > SW'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : n_q[XW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cur_q <= force_sample_i;
      ch_q <= channel_index_i;
      dt_q <= step_length_i;
      addr_q <= addr_in;
      in_range_q <= ({22'd0, channel_index_i} < 32'(Channels));
    end
    if (cmd_i.mul) begin
      sum_eff_q <= (mode_q == wta_pkg::MODE_CONTINUE) ? sum_rd_q : '0;
      ws_new_q <= (mode_q == wta_pkg::MODE_NEW_WINDOW) ? prev_rd_q : ws_rd_q;
      prod_q <= pair * $signed({1'b0, dt_q});
    end
    if (cmd_i.acc) begin
      neg_q <= sum_new[SW-1];
      n_q <= mag + SW'(elapsed_q);
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      if (!rem_sub[XW+1]) begin
        rem_q <= rem_sub;
        n_q <= {n_q[SW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        n_q <= {n_q[SW-2:0], 1'b0};
      end
    end
    if (cmd_i.load_out) begin
      average_force_o <= sts_o.need_div ? avg_res : cur_q;
      channel_echo_o <= ch_q;
    end
  end

endmodule
